FILE: rtl/esc_setpoint_and_current_limiter_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the ESC setpoint and current limiter
// Concurrent checks that compile away when NO_ASSERTIONS is defined.
// ---------------------------------------------------------------------------
`ifndef ESC_SETPOINT_AND_CURRENT_LIMITER_UNIT_ASSERT_SVH
`define ESC_SETPOINT_AND_CURRENT_LIMITER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define ESCL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define ESCL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ESCL_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define ESCL_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

FILE: rtl/escl_pkg.sv
// ---------------------------------------------------------------------------
// ESC limiter package
// Shared widths, constants, register indexes and control structures.
// ---------------------------------------------------------------------------
package escl_pkg;

   // field widths
   localparam int DutyW    = 8;
   localparam int PulseW   = 12;
   localparam int CurW     = 10;
   localparam int ProdW    = 16;
   localparam int ReqDataW = 40;
   localparam int ReqUserW = 3;
   localparam int RspDataW = 24;
   localparam int AddrW    = 5;
   localparam int CsrDataW = 32;
   localparam int RegIdxW  = 3;

   // divider: two quotient bits per step
   localparam int DivSteps = ProdW / 2;
   localparam int DivCntW  = $clog2(DivSteps);

   // scaling constants
   localparam logic [PulseW-1:0] PulseCutoff = 12'd300;
   localparam logic [PulseW-1:0] PulseClip   = 12'd200;
   localparam logic [DutyW-1:0]  PulseTop    = 8'd190;
   localparam logic [DutyW-1:0]  SerialFull  = 8'd200;
   localparam int                CeilShift   = 5;

   // register reset values
   localparam logic [DutyW-1:0] MaxPwmRst       = 8'd255;
   localparam logic [DutyW-1:0] MinPwmRst       = 8'd5;
   localparam logic [DutyW-1:0] MinPpmRst       = 8'd10;
   localparam logic [CurW-1:0]  MaxCurrentRst   = 10'd200;
   localparam logic [DutyW-1:0] LimitCurrentRst = 8'd120;

   // register indexes
   typedef enum logic [RegIdxW-1:0] {
      RegMaxPwm       = 3'd0,
      RegMinPwm       = 3'd1,
      RegMinPpm       = 3'd2,
      RegMaxCurrent   = 3'd3,
      RegLimitCurrent = 3'd4
   } reg_idx_type;

   typedef struct packed {
      logic [DutyW-1:0] max_pwm;
      logic [DutyW-1:0] min_pwm;
      logic [DutyW-1:0] min_ppm;
      logic [CurW-1:0]  max_current;
      logic [DutyW-1:0] limit_current;
   } cfg_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic mul;
      logic div_step;
      logic finish;
   } cmd_type;

endpackage

FILE: rtl/escl_csr.sv
// ---------------------------------------------------------------------------
// ESC limiter register file
// APB-style register bank holding the five configuration registers.
// ---------------------------------------------------------------------------
module escl_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [escl_pkg::AddrW-1:0]       csr_paddr,
   input  logic [escl_pkg::CsrDataW-1:0]    csr_pwdata,
   output logic [escl_pkg::CsrDataW-1:0]    csr_prdata,
   output logic                             csr_pready,
   output escl_pkg::cfg_type                cfg
);

   escl_pkg::cfg_type                cfg_ff;
   logic                             wr_en;
   logic [escl_pkg::RegIdxW-1:0]     idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign idx        = csr_paddr[escl_pkg::AddrW-1:2];
   assign cfg        = cfg_ff;

   // write registers on the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_pwm       <= escl_pkg::MaxPwmRst;
         cfg_ff.min_pwm       <= escl_pkg::MinPwmRst;
         cfg_ff.min_ppm       <= escl_pkg::MinPpmRst;
         cfg_ff.max_current   <= escl_pkg::MaxCurrentRst;
         cfg_ff.limit_current <= escl_pkg::LimitCurrentRst;
      end else if (wr_en) begin
         unique case (idx)
            escl_pkg::RegMaxPwm:       cfg_ff.max_pwm       <= csr_pwdata[7:0];
            escl_pkg::RegMinPwm:       cfg_ff.min_pwm       <= csr_pwdata[7:0];
            escl_pkg::RegMinPpm:       cfg_ff.min_ppm       <= csr_pwdata[7:0];
            escl_pkg::RegMaxCurrent:   cfg_ff.max_current   <= csr_pwdata[9:0];
            escl_pkg::RegLimitCurrent: cfg_ff.limit_current <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      unique case (idx)
         escl_pkg::RegMaxPwm:       csr_prdata = {24'd0, cfg_ff.max_pwm};
         escl_pkg::RegMinPwm:       csr_prdata = {24'd0, cfg_ff.min_pwm};
         escl_pkg::RegMinPpm:       csr_prdata = {24'd0, cfg_ff.min_ppm};
         escl_pkg::RegMaxCurrent:   csr_prdata = {22'd0, cfg_ff.max_current};
         escl_pkg::RegLimitCurrent: csr_prdata = {24'd0, cfg_ff.limit_current};
         default:                   csr_prdata = '0;
      endcase
   end

endmodule

FILE: rtl/escl_ctrl.sv
// ---------------------------------------------------------------------------
// ESC limiter controller
// Sequences accept, multiply, divide and finish, and owns the result valid.
// ---------------------------------------------------------------------------
module escl_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output escl_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      StIdle,
      StMul,
      StDiv,
      StFin
   } state_type;

   state_type                        state_ff;
   logic [escl_pkg::DivCntW-1:0]     count_ff;
   logic                             rsp_valid_ff;
   logic                             out_free;

   localparam logic [escl_pkg::DivCntW-1:0] LastStep =
      escl_pkg::DivCntW'(escl_pkg::DivSteps - 1);

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == StIdle);
   assign rsp_tvalid = rsp_valid_ff;

   // decode commands from state
   always_comb begin
      cmd.load     = (state_ff == StIdle) && req_tvalid;
      cmd.mul      = (state_ff == StMul);
      cmd.div_step = (state_ff == StDiv);
      cmd.finish   = (state_ff == StFin) && out_free;
   end

   // state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            StIdle: begin
               if (req_tvalid) state_ff <= StMul;
            end
            StMul: begin
               count_ff <= '0;
               state_ff <= StDiv;
            end
            StDiv: begin
               count_ff <= count_ff + 1'b1;
               if (count_ff == LastStep) state_ff <= StFin;
            end
            StFin: begin
               if (out_free) state_ff <= StIdle;
            end
            default: state_ff <= StIdle;
         endcase
         // raise on finish, drop once the result is taken
         if (cmd.finish) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

endmodule

FILE: rtl/escl_datapath.sv
// ---------------------------------------------------------------------------
// ESC limiter datapath
// Input hold, shared multiplier, radix-4 divider, setpoint and limiter state.
// ---------------------------------------------------------------------------
module escl_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  escl_pkg::cfg_type              cfg,
   input  escl_pkg::cmd_type              cmd,
   input  logic [escl_pkg::ReqDataW-1:0]  req_tdata,
   input  logic [escl_pkg::ReqUserW-1:0]  req_tuser,
   output logic [escl_pkg::RspDataW-1:0]  rsp_tdata
);

   localparam int DW = escl_pkg::DutyW;
   localparam int PW = escl_pkg::ProdW;

   // held input item
   logic                            bus_valid_ff, ser_valid_ff, pul_valid_ff, tick_ff;
   logic [DW-1:0]                   bus_sp_ff, ser_sp_ff;
   logic [escl_pkg::PulseW-1:0]     pul_w_ff;
   logic [escl_pkg::CurW-1:0]       cur_ff;

   // divider registers
   logic [PW-1:0]                   dq_ff, dq_in;
   logic [DW-1:0]                   rem_ff, rem_in;
   logic [DW-1:0]                   den_ff;

   // block state
   logic [DW-1:0]                   hold_ff, hold_in;
   logic [DW-1:0]                   mean_ff, mean_in;
   logic [DW-1:0]                   ceil_ff, ceil_in;
   logic                            pmode_ff, pmode_in;

   // result register
   logic [DW-1:0]                   duty_ff, duty_in;
   logic                            gates_ff, gates_in;
   logic                            red_ff, red_in;

   // pulse mapping helpers
   logic [escl_pkg::PulseW-1:0]     w1;
   logic [DW-1:0]                   w2, span, mul_a, mul_b;
   logic                            under, dead, use_ser, over;
   logic [PW-1:0]                   product;
   logic [PW:0]                     sp_raw;
   logic [DW-1:0]                   sp, ceil1;

   // two restoring divide steps
   function automatic logic [PW+DW-1:0] div2(input logic [DW-1:0] rem,
                                             input logic [PW-1:0] dq,
                                             input logic [DW-1:0] d);
      logic [DW:0]   r9;
      logic [DW-1:0] r;
      logic [PW-1:0] q;
      r = rem;
      q = dq;
      for (int k = 0; k < 2; k++) begin
         r9 = {r, q[PW-1]};
         if (r9 >= {1'b0, d}) begin
            r = DW'(r9 - {1'b0, d});
            q = {q[PW-2:0], 1'b1};
         end else begin
            r = r9[DW-1:0];
            q = {q[PW-2:0], 1'b0};
         end
      end
      return {r, q};
   endfunction

   // clip and map pulse width, pick multiplier operands
   always_comb begin
      w1      = (pul_w_ff > escl_pkg::PulseCutoff) ? '0 : pul_w_ff;
      w2      = (w1 > escl_pkg::PulseClip) ? escl_pkg::PulseClip[DW-1:0] : w1[DW-1:0];
      under   = (w2 <= cfg.min_ppm);
      dead    = (cfg.min_ppm >= escl_pkg::PulseTop);
      span    = (cfg.max_pwm >= cfg.min_pwm) ? (cfg.max_pwm - cfg.min_pwm) : '0;
      use_ser = !bus_valid_ff && ser_valid_ff;
      mul_a   = use_ser ? cfg.max_pwm : span;
      mul_b   = use_ser ? ser_sp_ff : (w2 - cfg.min_ppm);
      product = PW'(mul_a) * PW'(mul_b);
      {rem_in, dq_in} = div2(rem_ff, dq_ff, den_ff);
   end

   // setpoint choice, output stage and limiter
   always_comb begin
      over     = (cur_ff > cfg.max_current);
      pmode_in = pmode_ff;
      red_in   = 1'b0;
      if (bus_valid_ff) begin
         sp_raw   = {{(PW-DW+1){1'b0}}, bus_sp_ff};
         pmode_in = 1'b0;
      end else if (ser_valid_ff) begin
         sp_raw   = {1'b0, dq_ff};
         pmode_in = 1'b0;
      end else if (pul_valid_ff) begin
         pmode_in = 1'b1;
         if (under)     sp_raw = '0;
         else if (dead) sp_raw = {{(PW-DW+1){1'b0}}, cfg.max_pwm};
         else           sp_raw = {{(PW-DW+1){1'b0}}, cfg.min_pwm} + {1'b0, dq_ff};
      end else begin
         sp_raw = (hold_ff != '0) ? {{(PW-DW+1){1'b0}}, hold_ff - 1'b1} : '0;
         red_in = 1'b1;
      end
      sp      = (sp_raw > {{(PW-DW+1){1'b0}}, cfg.max_pwm}) ? cfg.max_pwm : sp_raw[DW-1:0];
      hold_in = sp;

      // cap at ceiling, cut on overcurrent
      duty_in = sp;
      if (sp > ceil_ff) begin
         duty_in = ceil_ff;
         red_in  = 1'b1;
      end
      gates_in = over;
      if (over) begin
         duty_in = '0;
         red_in  = 1'b1;
      end

      // track mean current and adapt ceiling
      mean_in = mean_ff;
      ceil_in = ceil_ff;
      ceil1   = ceil_ff;
      if (tick_ff) begin
         if ({2'b00, mean_ff} < cur_ff) begin
            if (mean_ff != 8'hFF) mean_in = mean_ff + 1'b1;
         end else if ({2'b00, mean_ff} > cur_ff) begin
            mean_in = mean_ff - 1'b1;
         end
         if (over) ceil1 = ceil_ff - (ceil_ff >> escl_pkg::CeilShift);
         if (mean_in > cfg.limit_current) begin
            ceil_in = (ceil1 != '0) ? ceil1 - 1'b1 : '0;
            red_in  = 1'b1;
         end else if (ceil1 < cfg.max_pwm) begin
            ceil_in = ceil1 + 1'b1;
         end else begin
            ceil_in = ceil1;
         end
      end
   end

   // capture item, multiply, divide
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         bus_valid_ff <= req_tuser[0];
         ser_valid_ff <= req_tuser[1];
         pul_valid_ff <= req_tuser[2];
         bus_sp_ff    <= req_tdata[7:0];
         ser_sp_ff    <= req_tdata[15:8];
         pul_w_ff     <= req_tdata[27:16];
         cur_ff       <= req_tdata[37:28];
         tick_ff      <= req_tdata[38];
      end
      if (cmd.mul) begin
         dq_ff  <= product;
         rem_ff <= '0;
         den_ff <= use_ser ? escl_pkg::SerialFull : (escl_pkg::PulseTop - cfg.min_ppm);
      end else if (cmd.div_step) begin
         dq_ff  <= dq_in;
         rem_ff <= rem_in;
      end
      if (cmd.finish) begin
         duty_ff  <= duty_in;
         gates_ff <= gates_in;
         red_ff   <= red_in;
      end
   end

   // block state, updated once per item
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff  <= '0;
         mean_ff  <= '0;
         ceil_ff  <= escl_pkg::MaxPwmRst;
         pmode_ff <= 1'b1;
      end else if (cmd.finish) begin
         hold_ff  <= hold_in;
         mean_ff  <= mean_in;
         ceil_ff  <= ceil_in;
         pmode_ff <= pmode_in;
      end
   end

   assign rsp_tdata = {5'd0, ceil_ff, pmode_ff, red_ff, gates_ff, duty_ff};

endmodule

FILE: rtl/esc_setpoint_and_current_limiter_unit.sv
// Sequence: an accepted item passes the multiply state, eight radix-4 divider
//   steps and the finish state, which waits while the output register is full
//   and not being taken. No new item is taken until the sequencer is idle again.
// An item is taken while the previous result still waits in the output register.
// Reset (synchronous, active high) restores register defaults, clears the
//   held setpoint and mean current, sets the ceiling to 255 and pulse mode on.
// ---------------------------------------------------------------------------
// ESC setpoint and current limiter
// Top level joining register bank, controller and datapath.
// ---------------------------------------------------------------------------
`include "esc_setpoint_and_current_limiter_unit_assert.svh"

module esc_setpoint_and_current_limiter_unit (
   input  logic                           clock,
   input  logic                           reset,
   // input item
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // bus_setpoint[7:0], serial_setpoint[15:8], pulse_width[27:16],
   // current_sample[37:28], limiter_tick[38], zero fill[39]
   input  logic [escl_pkg::ReqDataW-1:0]  req_tdata,
   // bus_valid[0], serial_valid[1], pulse_valid[2]
   input  logic [escl_pkg::ReqUserW-1:0]  req_tuser,
   // result item
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // duty[7:0], gates_off[8], red_led[9], pulse_mode[10],
   // duty_ceiling[18:11], zero fill[23:19]
   output logic [escl_pkg::RspDataW-1:0]  rsp_tdata,
   // configuration
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [escl_pkg::AddrW-1:0]     csr_paddr,
   input  logic [escl_pkg::CsrDataW-1:0]  csr_pwdata,
   output logic [escl_pkg::CsrDataW-1:0]  csr_prdata,
   output logic                           csr_pready
);

   escl_pkg::cfg_type cfg;
   escl_pkg::cmd_type cmd;

   escl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   escl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   escl_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata)
   );

   // busy once an item is taken
   `ESCL_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready, "item accepted while busy")
   // finish only into a free output register
   `ESCL_ASSERT_NOW(a_finish_free, clock, reset, cmd.finish, !rsp_tvalid || rsp_tready, "result overwritten")
   // a result appears only after a finish
   `ESCL_ASSERT_NOW(a_valid_from_finish, clock, reset, $rose(rsp_tvalid), $past(cmd.finish), "result without finish")

endmodule

FILE: tb/sv/esc_setpoint_and_current_limiter_unit_tb.sv
// ---------------------------------------------------------------------------
// ESC setpoint and current limiter testbench
// Drives control updates through the streaming input under bursty traffic and
// a stalling receiver, predicts every result and compares it field by field.
// Starts with a directed stimulus table at the reset settings, then runs
// random updates under several register settings, the extremes among them.
// ---------------------------------------------------------------------------
module esc_setpoint_and_current_limiter_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // run shape
   localparam int NumRows      = 24;
   localparam int NumSettings  = 7;
   localparam int RandPerPhase = 147;
   localparam int HoldCycles   = 300;
   localparam int DrainCycles  = 12;
   localparam int QuietLimit   = 4000;
   localparam int MaxReported  = 10;

   // limiter constants
   localparam int unsigned SerFullScale = 200;
   localparam int unsigned PulseCut     = 300;
   localparam int unsigned PulseClipW   = 200;
   localparam int unsigned PulseTopW    = 190;
   localparam int unsigned CeilDivShift = 5;

   typedef struct packed {
      logic        bus_ok;
      logic [7:0]  bus_sp;
      logic        ser_ok;
      logic [7:0]  ser_sp;
      logic        pls_ok;
      logic [11:0] pls_w;
      logic [9:0]  amps;
      logic        tick;
   } update_type;

   typedef struct packed {
      logic [7:0] duty;
      logic       gates_off;
      logic       red_led;
      logic       pulse_mode;
      logic [7:0] ceiling;
   } drive_type;

   typedef struct packed {
      update_type upd;
      logic       typed;
      drive_type  want;
   } bench_row_type;

   // directed stimulus at the reset settings; typed results where obvious
   localparam bench_row_type BenchRows [NumRows] = '{
      // no source after reset: hold stays at zero, red lamp on
      '{'{1'b0,8'd0,1'b0,8'd0,1'b0,12'd0,10'd0,1'b0},1'b1,'{8'd0,1'b0,1'b1,1'b1,8'd255}},
      // bus extremes
      '{'{1'b1,8'd255,1'b0,8'd0,1'b0,12'd0,10'd0,1'b0},1'b1,'{8'd255,1'b0,1'b0,1'b0,8'd255}},
      '{'{1'b1,8'd0,1'b0,8'd0,1'b0,12'd0,10'd0,1'b0},1'b1,'{8'd0,1'b0,1'b0,1'b0,8'd255}},
      // serial full scale, over scale (clamped), zero
      '{'{1'b0,8'd0,1'b1,8'd200,1'b0,12'd0,10'd0,1'b0},1'b1,'{8'd255,1'b0,1'b0,1'b0,8'd255}},
      '{'{1'b0,8'd0,1'b1,8'd255,1'b0,12'd0,10'd0,1'b0},1'b1,'{8'd255,1'b0,1'b0,1'b0,8'd255}},
      '{'{1'b0,8'd0,1'b1,8'd0,1'b0,12'd0,10'd0,1'b0},1'b1,'{8'd0,1'b0,1'b0,1'b0,8'd255}},
      // pulse: dead zone, top, clip, cutoff edge, beyond cutoff, widest
      '{'{1'b0,8'd0,1'b0,8'd0,1'b1,12'd10,10'd0,1'b0},1'b1,'{8'd0,1'b0,1'b0,1'b1,8'd255}},
      '{'{1'b0,8'd0,1'b0,8'd0,1'b1,12'd190,10'd0,1'b0},1'b1,'{8'd255,1'b0,1'b0,1'b1,8'd255}},
      '{'{1'b0,8'd0,1'b0,8'd0,1'b1,12'd200,10'd0,1'b0},1'b1,'{8'd255,1'b0,1'b0,1'b1,8'd255}},
      '{'{1'b0,8'd0,1'b0,8'd0,1'b1,12'd300,10'd0,1'b0},1'b1,'{8'd255,1'b0,1'b0,1'b1,8'd255}},
      '{'{1'b0,8'd0,1'b0,8'd0,1'b1,12'd301,10'd0,1'b0},1'b1,'{8'd0,1'b0,1'b0,1'b1,8'd255}},
      '{'{1'b0,8'd0,1'b0,8'd0,1'b1,12'd4095,10'd0,1'b0},1'b1,'{8'd0,1'b0,1'b0,1'b1,8'd255}},
      // mid-range pulse, then decay with no source
      '{'{1'b0,8'd0,1'b0,8'd0,1'b1,12'd100,10'd0,1'b0},1'b0,'0},
      '{'{1'b0,8'd0,1'b0,8'd0,1'b0,12'd0,10'd0,1'b0},1'b0,'0},
      // all sources valid: bus wins
      '{'{1'b1,8'd100,1'b1,8'd200,1'b1,12'd190,10'd0,1'b0},1'b1,'{8'd100,1'b0,1'b0,1'b0,8'd255}},
      // decay keeps the bus source mode
      '{'{1'b0,8'd0,1'b0,8'd0,1'b0,12'd0,10'd0,1'b0},1'b0,'0},
      // overcurrent cuts the gates; current equal to the limit does not
      '{'{1'b1,8'd255,1'b0,8'd0,1'b0,12'd0,10'd1023,1'b0},1'b1,'{8'd0,1'b1,1'b1,1'b0,8'd255}},
      '{'{1'b1,8'd50,1'b0,8'd0,1'b0,12'd0,10'd200,1'b0},1'b1,'{8'd50,1'b0,1'b0,1'b0,8'd255}},
      // overcurrent on a tick shrinks the ceiling, then the cap bites
      '{'{1'b1,8'd50,1'b0,8'd0,1'b0,12'd0,10'd201,1'b1},1'b0,'0},
      '{'{1'b1,8'd255,1'b0,8'd0,1'b0,12'd0,10'd0,1'b0},1'b0,'0},
      '{'{1'b0,8'd0,1'b1,8'd128,1'b0,12'd0,10'd0,1'b1},1'b0,'0},
      '{'{1'b0,8'd0,1'b0,8'd0,1'b1,12'd3000,10'd1023,1'b1},1'b0,'0},
      // alternating bit patterns in ignored fields
      '{'{1'b0,8'hAA,1'b0,8'h55,1'b1,12'hA96,10'd512,1'b1},1'b0,'0},
      '{'{1'b0,8'h55,1'b1,8'hAA,1'b0,12'h569,10'h2AA,1'b0},1'b0,'0}
   };

   logic                          clock;
   logic                          reset;
   logic                          req_tvalid;
   logic                          req_tready;
   // bus_setpoint, serial_setpoint, pulse_width, current_sample, limiter_tick, zero
   logic [escl_pkg::ReqDataW-1:0] req_tdata;
   // bus_valid, serial_valid, pulse_valid
   logic [escl_pkg::ReqUserW-1:0] req_tuser;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   // duty, gates_off, red_led, pulse_mode, duty_ceiling, zero
   logic [escl_pkg::RspDataW-1:0] rsp_tdata;
   logic                          csr_psel;
   logic                          csr_penable;
   logic                          csr_pwrite;
   logic [escl_pkg::AddrW-1:0]    csr_paddr;
   logic [escl_pkg::CsrDataW-1:0] csr_pwdata;
   logic [escl_pkg::CsrDataW-1:0] csr_prdata;
   logic                          csr_pready;

   // predicted limiter state and settings
   escl_pkg::cfg_type lim_cfg;
   logic [7:0]        sp_held;
   logic [7:0]        mean_amps;
   logic [7:0]        duty_cap;
   logic              pulse_src;
   logic              red_lit;

   drive_type due_drives [$];

   int mismatch_count  = 0;
   int updates_sent;
   int results_checked = 0;
   int over_hits;
   int cap_hits;
   int mean_falls;
   int mean_sat;
   int quiet_cycles    = 0;
   int hold_req;
   int hold_seen       = 0;
   int hold_left       = 0;
   int rx_mode         = 0;
   int rx_mode_left    = 0;
   int rx_beat         = 0;

   esc_setpoint_and_current_limiter_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Work out the result of one update and advance the predicted state.
   function automatic drive_type predict_update(input update_type u);
      int unsigned sp;
      int unsigned w;
      int unsigned span;
      int unsigned duty;
      logic        over;
      drive_type   r;
      over = u.amps > lim_cfg.max_current;
      sp = sp_held;
      // pick the source in priority order
      if (u.bus_ok) begin
         sp = u.bus_sp;
         pulse_src = 1'b0;
         red_lit = 1'b0;
      end else if (u.ser_ok) begin
         sp = (int'(lim_cfg.max_pwm) * int'(u.ser_sp)) / SerFullScale;
         pulse_src = 1'b0;
         red_lit = 1'b0;
      end else if (u.pls_ok) begin
         w = u.pls_w;
         if (w > PulseCut) w = 0;
         if (w > PulseClipW) w = PulseClipW;
         if (w <= lim_cfg.min_ppm) begin
            sp = 0;
         end else if (lim_cfg.min_ppm >= PulseTopW) begin
            sp = lim_cfg.max_pwm;
         end else begin
            span = (lim_cfg.max_pwm >= lim_cfg.min_pwm) ?
                   int'(lim_cfg.max_pwm) - int'(lim_cfg.min_pwm) : 0;
            sp = lim_cfg.min_pwm + span * (w - lim_cfg.min_ppm) /
                 (PulseTopW - lim_cfg.min_ppm);
         end
         pulse_src = 1'b1;
         red_lit = 1'b0;
      end else begin
         if (sp != 0) sp--;
         red_lit = 1'b1;
      end
      if (sp > lim_cfg.max_pwm) sp = lim_cfg.max_pwm;
      sp_held = sp[7:0];
      // cap at the ceiling held before this tick, then cut on overcurrent
      duty = sp;
      if (duty > duty_cap) begin
         duty = duty_cap;
         red_lit = 1'b1;
         cap_hits++;
      end
      if (over) begin
         duty = 0;
         red_lit = 1'b1;
         over_hits++;
      end
      // limiter tick: mean follows the sample, ceiling adapts
      if (u.tick) begin
         if (mean_amps < u.amps) begin
            if (mean_amps != 8'd255) mean_amps++;
         end else if (mean_amps > u.amps) begin
            mean_amps--;
         end
         if (mean_amps == 8'd255) mean_sat++;
         if (over) duty_cap = duty_cap - (duty_cap >> CeilDivShift);
         if (mean_amps > lim_cfg.limit_current) begin
            if (duty_cap != 0) duty_cap--;
            red_lit = 1'b1;
            mean_falls++;
         end else if (duty_cap < lim_cfg.max_pwm) begin
            duty_cap++;
         end
      end
      r.duty = duty[7:0];
      r.gates_off = over;
      r.red_led = red_lit;
      r.pulse_mode = pulse_src;
      r.ceiling = duty_cap;
      return r;
   endfunction

   // Draw one random update: mostly valid sources, currents near a phase level.
   function automatic update_type draw_update(input int amps_base);
      int         pick;
      int         pick_w;
      int         c;
      update_type u;
      pick = $urandom_range(0, 99);
      u.bus_ok = (pick < 25);
      u.ser_ok = (pick < 25) ? 1'($urandom_range(0, 1)) : (pick < 50);
      u.pls_ok = (pick < 50) ? 1'($urandom_range(0, 1)) : (pick < 80);
      u.bus_sp = 8'($urandom_range(0, 255));
      u.ser_sp = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 200)) :
                                              8'($urandom_range(0, 255));
      pick_w = $urandom_range(0, 4);
      if (pick_w < 3)       u.pls_w = 12'($urandom_range(0, 210));
      else if (pick_w == 3) u.pls_w = 12'($urandom_range(290, 310));
      else                  u.pls_w = 12'($urandom_range(0, 4095));
      if ($urandom_range(0, 9) < 6) begin
         c = amps_base + int'($urandom_range(0, 48)) - 24;
         if (c < 0) c = 0;
         if (c > 1023) c = 1023;
         u.amps = 10'(c);
      end else begin
         u.amps = 10'($urandom_range(0, 1023));
      end
      u.tick = ($urandom_range(0, 9) < 7);
      return u;
   endfunction

   // Offer one update after an idle gap and record its result on acceptance.
   task automatic offer_update(input update_type u, input int gap, input logic typed,
                               input drive_type want);
      drive_type pred;
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, u.tick, u.amps, u.pls_w, u.ser_sp, u.bus_sp};
      req_tuser  <= {u.pls_ok, u.ser_ok, u.bus_ok};
      do @(posedge clock); while (!req_tready);
      pred = predict_update(u);
      due_drives.push_back(typed ? want : pred);
      updates_sent++;
   endtask

   // Stop offering, wait for every result, then let the block settle.
   task automatic drain_block();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (due_drives.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Write one register through a setup and an access cycle.
   task automatic write_reg(input escl_pkg::reg_idx_type idx,
                            input logic [escl_pkg::CsrDataW-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         escl_pkg::RegMaxPwm:       lim_cfg.max_pwm = value[7:0];
         escl_pkg::RegMinPwm:       lim_cfg.min_pwm = value[7:0];
         escl_pkg::RegMinPpm:       lim_cfg.min_ppm = value[7:0];
         escl_pkg::RegMaxCurrent:   lim_cfg.max_current = value[9:0];
         escl_pkg::RegLimitCurrent: lim_cfg.limit_current = value[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic report_field(input string name, input int want, input int got);
      if (want != got) begin
         mismatch_count++;
         if (mismatch_count <= MaxReported)
            $display("mismatch on result %0d, %0s: expected %0d, got %0d",
                     results_checked, name, want, got);
      end
   endtask

   // Receiver: stall on a pattern of its own, or hold off when asked.
   always @(negedge clock) begin
      rx_beat++;
      if (hold_seen != hold_req) begin
         hold_seen = hold_req;
         hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(16, 96);
         end
         rx_mode_left--;
         case (rx_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= 1'($urandom_range(0, 1));
            default: rsp_tready <= (rx_beat % 4 == 3);
         endcase
      end
   end

   // Compare each accepted result with the oldest prediction.
   always @(posedge clock) begin : check_results
      drive_type got;
      drive_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[7:0], rsp_tdata[8], rsp_tdata[9], rsp_tdata[10], rsp_tdata[18:11]};
         if (due_drives.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MaxReported)
               $display("result with nothing pending: %h", rsp_tdata);
         end else begin
            want = due_drives.pop_front();
            report_field("duty", want.duty, got.duty);
            report_field("gates_off", want.gates_off, got.gates_off);
            report_field("red_led", want.red_led, got.red_led);
            report_field("pulse_mode", want.pulse_mode, got.pulse_mode);
            report_field("duty_ceiling", want.ceiling, got.ceiling);
            results_checked++;
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
         $display("watchdog: no traffic for %0d cycles, %0d results outstanding",
                  quiet_cycles, due_drives.size());
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      escl_pkg::cfg_type next_cfg;
      int                ph;
      int                n;
      int                gap;
      int                burst_left;
      int                amps_base;
      // known values on every input from the start
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      updates_sent = 0;
      over_hits = 0;
      cap_hits = 0;
      mean_falls = 0;
      mean_sat = 0;
      hold_req = 0;
      burst_left = 0;
      // reset state of the predictor
      lim_cfg.max_pwm       = 8'd255;
      lim_cfg.min_pwm       = 8'd5;
      lim_cfg.min_ppm       = 8'd10;
      lim_cfg.max_current   = 10'd200;
      lim_cfg.limit_current = 8'd120;
      sp_held   = 8'd0;
      mean_amps = 8'd0;
      duty_cap  = 8'd255;
      pulse_src = 1'b1;
      red_lit   = 1'b1;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table at the reset settings
      for (n = 0; n < NumRows; n++)
         offer_update(BenchRows[n].upd, $urandom_range(0, 2), BenchRows[n].typed,
                      BenchRows[n].want);

      // random phases, each under its own register settings
      for (ph = 0; ph < NumSettings; ph++) begin
         drain_block();
         case (ph)
            0: next_cfg = '{8'd1, 8'd255, 8'd189, 10'd0, 8'd0};
            1: next_cfg = '{8'd255, 8'd0, 8'd0, 10'd1023, 8'd255};
            NumSettings - 1: next_cfg = '{8'd255, 8'd5, 8'd10, 10'd200, 8'd120};
            default: begin
               next_cfg.max_pwm       = 8'($urandom_range(1, 255));
               next_cfg.min_pwm       = 8'($urandom_range(0, 255));
               next_cfg.min_ppm       = 8'($urandom_range(0, 189));
               next_cfg.max_current   = 10'($urandom_range(0, 1023));
               next_cfg.limit_current = 8'($urandom_range(0, 255));
            end
         endcase
         write_reg(escl_pkg::RegMaxPwm, 32'(next_cfg.max_pwm));
         write_reg(escl_pkg::RegMinPwm, 32'(next_cfg.min_pwm));
         write_reg(escl_pkg::RegMinPpm, 32'(next_cfg.min_ppm));
         write_reg(escl_pkg::RegMaxCurrent, 32'(next_cfg.max_current));
         write_reg(escl_pkg::RegLimitCurrent, 32'(next_cfg.limit_current));
         amps_base = $urandom_range(0, 1023);
         for (n = 0; n < RandPerPhase; n++) begin
            // long receiver hold-off while items keep coming
            if (n == 30) hold_req++;
            // sender pause until the block has emptied
            if (n == 110) drain_block();
            gap = 0;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 10);
            end
            burst_left--;
            offer_update(draw_update(amps_base), gap, 1'b0, '0);
         end
      end

      drain_block();
      $display("covered %0d updates and %0d results over %0d register settings",
               updates_sent, results_checked, NumSettings + 1);
      $display("overcurrent %0d, ceiling cap %0d, mean over limit %0d, mean saturated %0d",
               over_hits, cap_hits, mean_falls, mean_sat);
      if (mismatch_count == 0 && due_drives.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches, %0d results outstanding", mismatch_count,
                  due_drives.size());
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/escl_pkg.sv
rtl/escl_csr.sv
rtl/escl_ctrl.sv
rtl/escl_datapath.sv
rtl/esc_setpoint_and_current_limiter_unit.sv
tb/sv/esc_setpoint_and_current_limiter_unit_tb.sv
